@@ rtl/bcfb_pkg.sv @@
`default_nettype none
package bcfb_pkg;

   localparam logic [7:0] FRAME_START = 8'h02;
   localparam logic [7:0] FRAME_END   = 8'h03;
   localparam logic [7:0] CODE_ONE    = 8'h24;
   localparam logic [7:0] CODE_FEW    = 8'h14;
   localparam logic [7:0] CODE_MANY   = 8'h0C;
   localparam logic [7:0] CODE_NONE   = 8'h00;
   localparam logic [7:0] MODE_RUN    = 8'h80;
   localparam logic [7:0] MODE_SHOWER = 8'h40;
   localparam logic [7:0] MODE_MASK   = 8'h7f;

   localparam int FRAME_LEN   = 6;
   localparam int FIFO_DEPTH  = 2;

   localparam logic [1:0] REG_HEAT_MIN   = 2'd0;
   localparam logic [1:0] REG_HEAT_MAX   = 2'd1;
   localparam logic [1:0] REG_SHOWER_MIN = 2'd2;
   localparam logic [1:0] REG_HOLD       = 2'd3;

   localparam logic [6:0] HEAT_MIN_RST   = 7'd45;
   localparam logic [6:0] HEAT_MAX_RST   = 7'd85;
   localparam logic [6:0] SHOWER_MIN_RST = 7'd35;
   localparam logic [1:0] HOLD_RST       = 2'd2;

   localparam logic KIND_BUILD = 1'b0;
   localparam logic KIND_RESET = 1'b1;

   typedef struct packed {
      logic [6:0] heat_min;
      logic [6:0] heat_max;
      logic [6:0] shower_min;
      logic [1:0] hold_frames;
   } cfg_type;

   typedef struct packed {
      logic [7:0] mode;
      logic [7:0] heat_bcd;
      logic [7:0] shower_bcd;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage
`default_nettype wire

@@ rtl/bcfb_front.sv @@
`default_nettype none
module bcfb_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bcfb_pkg::cfg_type   cfg,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [39:0]         req_tdata,
   input  wire logic                req_tuser,
   input  wire bcfb_pkg::fifo_status_type fifo_status,
   output logic                     push,
   output bcfb_pkg::entry_type      push_entry
);

   logic       pending_ff, pending_in;
   logic [1:0] countdown_ff, countdown_in;

   logic       accept;
   logic [7:0] open_mask;
   logic [3:0] open_count;
   logic [7:0] code;
   logic [7:0] mode;
   logic       shower;
   logic [7:0] heat;
   logic [7:0] shw;
   logic [7:0] heat_lo;

   function automatic logic [7:0] to_bcd(input logic [7:0] v);
      logic [6:0] s;
      logic [3:0] tens;
      logic [6:0] rest;
      s = (v > 8'd99) ? 7'd99 : v[6:0];
      tens = 4'd0;
      for (int i = 1; i < 10; i++) begin
         if (s >= 7'(i * 10)) begin
            tens = 4'(i);
         end
      end
      rest = s - 7'({3'd0, tens} * 7'd10);
      return {tens, rest[3:0]};
   endfunction

   assign req_tready = !fifo_status.full;
   assign accept = req_tvalid && req_tready;

   assign open_mask = req_tdata[7:0] | req_tdata[15:8];
   assign shower = req_tdata[16];

   always_comb begin
      open_count = 4'd0;
      for (int i = 0; i < 8; i++) begin
         open_count = open_count + {3'd0, open_mask[i]};
      end
   end

   always_comb begin
      if (open_count == 4'd1) begin
         code = bcfb_pkg::CODE_ONE;
      end else if (open_count == 4'd2 || open_count == 4'd3) begin
         code = bcfb_pkg::CODE_FEW;
      end else if (open_count >= 4'd4) begin
         code = bcfb_pkg::CODE_MANY;
      end else begin
         code = bcfb_pkg::CODE_NONE;
      end
   end

   always_comb begin
      pending_in = pending_ff;
      countdown_in = countdown_ff;
      mode = bcfb_pkg::MODE_RUN;
      if (accept && req_tuser == bcfb_pkg::KIND_RESET) begin
         if (!pending_ff) begin
            pending_in = 1'b1;
            countdown_in = cfg.hold_frames;
         end
      end else if (pending_ff) begin
         if (countdown_ff == 2'd0) begin
            if (accept) begin
               pending_in = 1'b0;
               countdown_in = cfg.hold_frames;
            end
         end else begin
            if (accept) begin
               countdown_in = countdown_ff - 2'd1;
            end
            mode = 8'h00;
         end
      end
      if (shower) begin
         mode = mode | bcfb_pkg::MODE_SHOWER;
      end
      mode = mode | code;
      if (code == bcfb_pkg::CODE_NONE) begin
         mode = mode & bcfb_pkg::MODE_MASK;
         if (shower) begin
            mode = mode | bcfb_pkg::MODE_RUN;
         end
      end
   end

   always_comb begin
      heat_lo = (req_tdata[24:17] < {1'b0, cfg.heat_min}) ? {1'b0, cfg.heat_min}
                                                          : req_tdata[24:17];
      heat = (heat_lo > {1'b0, cfg.heat_max}) ? {1'b0, cfg.heat_max} : heat_lo;
      shw = (req_tdata[32:25] < {1'b0, cfg.shower_min}) ? {1'b0, cfg.shower_min}
                                                        : req_tdata[32:25];
   end

   assign push = accept && req_tuser == bcfb_pkg::KIND_BUILD;
   assign push_entry.mode = mode;
   assign push_entry.heat_bcd = to_bcd(heat);
   assign push_entry.shower_bcd = to_bcd(shw);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         countdown_ff <= bcfb_pkg::HOLD_RST;
      end else begin
         pending_ff <= pending_in;
         countdown_ff <= countdown_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/bcfb_fifo.sv @@
`default_nettype none
module bcfb_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire bcfb_pkg::entry_type push_entry,
   input  wire logic                pop,
   output bcfb_pkg::entry_type      head,
   output bcfb_pkg::fifo_status_type status
);

   localparam int PTR_W = $clog2(bcfb_pkg::FIFO_DEPTH);
   localparam int CNT_W = $clog2(bcfb_pkg::FIFO_DEPTH + 1);

   bcfb_pkg::entry_type mem_ff [bcfb_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full = count_ff == CNT_W'(bcfb_pkg::FIFO_DEPTH);
   assign status.empty = count_ff == '0;
   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(bcfb_pkg::FIFO_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(bcfb_pkg::FIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/bcfb_back.sv @@
`default_nettype none
module bcfb_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bcfb_pkg::entry_type head,
   input  wire bcfb_pkg::fifo_status_type fifo_status,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast
);

   localparam int IDX_W = $clog2(bcfb_pkg::FRAME_LEN);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(bcfb_pkg::FRAME_LEN - 1);

   bcfb_pkg::entry_type cur_ff, cur_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_data_ff, out_data_in;
   logic             out_last_ff, out_last_in;
   logic             advance;
   logic [7:0]       sel_byte;

   assign advance = cur_valid_ff && (!out_valid_ff || rsp_tready);
   assign pop = !fifo_status.empty && (!cur_valid_ff || (advance && idx_ff == LAST_IDX));

   always_comb begin
      case (idx_ff)
         IDX_W'(0): sel_byte = bcfb_pkg::FRAME_START;
         IDX_W'(1): sel_byte = cur_ff.mode;
         IDX_W'(2): sel_byte = cur_ff.heat_bcd;
         IDX_W'(3): sel_byte = cur_ff.shower_bcd;
         IDX_W'(4): sel_byte = bcfb_pkg::FRAME_START ^ cur_ff.mode ^ cur_ff.heat_bcd
                               ^ cur_ff.shower_bcd;
         default:   sel_byte = bcfb_pkg::FRAME_END;
      endcase
   end

   always_comb begin
      cur_in = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in = idx_ff;
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in = sel_byte;
         out_last_in = idx_ff == LAST_IDX;
         if (idx_ff == LAST_IDX) begin
            idx_in = '0;
            cur_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (pop) begin
         cur_in = head;
         cur_valid_in = 1'b1;
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;

endmodule
`default_nettype wire

@@ rtl/boiler_command_frame_builder.sv @@
// Boiler command frame builder.
// Requests arrive on the req_ stream. A request with tuser low builds one
// six-byte command frame; a request with tuser high arms an error reset and
// produces no output. Frames leave on the rsp_ stream one byte per transfer,
// with tlast on the sixth byte.
// The front stage classifies each request in the cycle it is accepted and
// writes the frame fields into a two-entry queue; the back stage drains the
// queue and shifts out bytes through an output register.
// The first byte of a frame passes through the queue, the current-frame register
// and the output register. With the receiver always ready, frame output is
// limited by the single byte lane of the back stage, and requests are taken
// back to back while the queue has room.
// When the receiver stalls, the output byte holds, the queue fills and
// req_tready drops; reset-request transfers are also held back then.
// Settings are written on the csr_ port, which is always ready, and should
// only change while no frame is in flight. Reset clears the queue, the
// output stage and the error-reset hold, and restores the default settings.
`default_nettype none
module boiler_command_frame_builder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] valve_mask_main, [15:8] valve_mask_sub, [16] shower_active,
   // [24:17] heat_setpoint, [32:25] shower_setpoint, [39:33] zero
   input  wire logic [39:0] req_tdata,
   // [0] kind
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] frame_byte
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_data
);

   bcfb_pkg::cfg_type cfg_ff, cfg_in;
   bcfb_pkg::entry_type push_entry;
   bcfb_pkg::entry_type head;
   bcfb_pkg::fifo_status_type fifo_status;
   logic push;
   logic pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bcfb_pkg::REG_HEAT_MIN:   cfg_in.heat_min = csr_data;
            bcfb_pkg::REG_HEAT_MAX:   cfg_in.heat_max = csr_data;
            bcfb_pkg::REG_SHOWER_MIN: cfg_in.shower_min = csr_data;
            bcfb_pkg::REG_HOLD:       cfg_in.hold_frames = csr_data[1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heat_min <= bcfb_pkg::HEAT_MIN_RST;
         cfg_ff.heat_max <= bcfb_pkg::HEAT_MAX_RST;
         cfg_ff.shower_min <= bcfb_pkg::SHOWER_MIN_RST;
         cfg_ff.hold_frames <= bcfb_pkg::HOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bcfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .fifo_status (fifo_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   bcfb_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (fifo_status)
   );

   bcfb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ dv/boiler_frame_checker.sv @@
`default_nettype none
module boiler_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_data,
   output int               bytes_due,
   output int               mismatches
);

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   frame_byte_type        frame_bytes_due[$];
   bcfb_pkg::cfg_type     limits;
   logic                  hold_armed;
   logic [1:0]            hold_left;
   int                    errors = 0;

   function automatic logic [7:0] bcd_byte(input logic [7:0] value);
      logic [7:0] capped;
      logic [7:0] tens;
      logic [7:0] ones;
      capped = (value > 8'd99) ? 8'd99 : value;
      tens = capped / 8'd10;
      ones = capped % 8'd10;
      return {tens[3:0], ones[3:0]};
   endfunction

   function automatic logic [7:0] mode_byte(input logic [7:0] open_mask, input logic shower,
                                            input logic run);
      logic [7:0] code;
      logic [7:0] mode;
      case ($countones(open_mask))
         0: code = bcfb_pkg::CODE_NONE;
         1: code = bcfb_pkg::CODE_ONE;
         2, 3: code = bcfb_pkg::CODE_FEW;
         default: code = bcfb_pkg::CODE_MANY;
      endcase
      mode = run ? bcfb_pkg::MODE_RUN : 8'h00;
      if (shower) mode = mode | bcfb_pkg::MODE_SHOWER;
      mode = mode | code;
      // With no valve open, bit 7 carries the shower flag instead of the run flag.
      if (code == bcfb_pkg::CODE_NONE)
         mode = (mode & bcfb_pkg::MODE_MASK) | (shower ? bcfb_pkg::MODE_RUN : 8'h00);
      return mode;
   endfunction

   always @(posedge clock) begin
      frame_byte_type want;
      logic [7:0]  heat;
      logic [7:0]  shower_temp;
      logic [7:0]  mode;
      logic [7:0]  heat_bcd;
      logic [7:0]  shower_bcd;
      logic        run;
      if (reset) begin
         limits = '{bcfb_pkg::HEAT_MIN_RST, bcfb_pkg::HEAT_MAX_RST,
                    bcfb_pkg::SHOWER_MIN_RST, bcfb_pkg::HOLD_RST};
         hold_armed = 1'b0;
         hold_left = bcfb_pkg::HOLD_RST;
         frame_bytes_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (frame_bytes_due.size() == 0) begin
               $error("frame_byte: no byte expected, got %h (last_byte %b)", rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               want = frame_bytes_due.pop_front();
               if (rsp_tdata !== want.data) begin
                  $error("frame_byte: expected %h, got %h", want.data, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_byte: expected %b, got %b", want.last, rsp_tlast);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bcfb_pkg::REG_HEAT_MIN: limits.heat_min = csr_data;
               bcfb_pkg::REG_HEAT_MAX: limits.heat_max = csr_data;
               bcfb_pkg::REG_SHOWER_MIN: limits.shower_min = csr_data;
               bcfb_pkg::REG_HOLD: limits.hold_frames = csr_data[1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == bcfb_pkg::KIND_RESET) begin
               if (!hold_armed) begin
                  hold_armed = 1'b1;
                  hold_left = limits.hold_frames;
               end
            end else begin
               run = 1'b1;
               if (hold_armed) begin
                  if (hold_left == 2'd0) begin
                     hold_armed = 1'b0;
                     hold_left = limits.hold_frames;
                  end else begin
                     hold_left = hold_left - 2'd1;
                     run = 1'b0;
                  end
               end
               mode = mode_byte(req_tdata[7:0] | req_tdata[15:8], req_tdata[16], run);
               heat = req_tdata[24:17];
               if (heat < {1'b0, limits.heat_min}) heat = {1'b0, limits.heat_min};
               if (heat > {1'b0, limits.heat_max}) heat = {1'b0, limits.heat_max};
               shower_temp = req_tdata[32:25];
               if (shower_temp < {1'b0, limits.shower_min})
                  shower_temp = {1'b0, limits.shower_min};
               heat_bcd = bcd_byte(heat);
               shower_bcd = bcd_byte(shower_temp);
               frame_bytes_due.push_back('{bcfb_pkg::FRAME_START, 1'b0});
               frame_bytes_due.push_back('{mode, 1'b0});
               frame_bytes_due.push_back('{heat_bcd, 1'b0});
               frame_bytes_due.push_back('{shower_bcd, 1'b0});
               frame_bytes_due.push_back('{bcfb_pkg::FRAME_START ^ mode ^ heat_bcd
                                           ^ shower_bcd, 1'b0});
               frame_bytes_due.push_back('{bcfb_pkg::FRAME_END, 1'b1});
            end
         end
      end
      bytes_due <= frame_bytes_due.size();
      mismatches <= errors;
   end

endmodule
`default_nettype wire

@@ dv/boiler_command_frame_builder_test.sv @@
`default_nettype none
module boiler_command_frame_builder_test;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_STALL = 90;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = bcfb_pkg::KIND_BUILD;
   logic        rsp_tready = 1'b0;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = bcfb_pkg::REG_HEAT_MIN;
   logic [6:0]  csr_data = '0;
   wire logic       req_tready;
   wire logic       rsp_tvalid;
   wire logic [7:0] rsp_tdata;
   wire logic       rsp_tlast;
   wire logic       csr_ready;
   int bytes_due;
   int mismatches;

   int tx_idle_pct = 18;
   int rx_idle_pct = 48;
   int long_stalls_asked = 0;
   int long_stalls_taken = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   boiler_command_frame_builder DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   boiler_frame_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .bytes_due(bytes_due), .mismatches(mismatches)
   );

   always #5 clock = ~clock;

   // A long hold-off lets the request queue fill so that req_tready drops.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (long_stalls_taken != long_stalls_asked) begin
         long_stalls_taken <= long_stalls_asked;
         stall_left <= LONG_STALL;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic kind, input logic [7:0] mask_main,
                               input logic [7:0] mask_sub, input logic shower,
                               input logic [7:0] heat, input logic [7:0] shower_temp);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, shower_temp, heat, shower, mask_sub, mask_main};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic csr_put(input logic [1:0] index, input logic [6:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_limits(input logic [6:0] heat_lo, input logic [6:0] heat_hi,
                             input logic [6:0] shower_lo, input logic [1:0] hold);
      csr_put(bcfb_pkg::REG_HEAT_MIN, heat_lo);
      csr_put(bcfb_pkg::REG_HEAT_MAX, heat_hi);
      csr_put(bcfb_pkg::REG_SHOWER_MIN, shower_lo);
      csr_put(bcfb_pkg::REG_HOLD, {5'd0, hold});
      csr_valid <= 1'b0;
   endtask

   task automatic drain_frames();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (bytes_due != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic send_random_frame();
      logic [7:0] mask_main;
      logic [7:0] mask_sub;
      logic [7:0] heat;
      logic [7:0] shower_temp;
      case ($urandom_range(3))
         0: begin
            mask_main = '0;
            mask_sub = '0;
         end
         1: begin
            mask_main = 8'd1 << $urandom_range(7);
            mask_sub = mask_main;
         end
         2: begin
            mask_main = 8'd1 << $urandom_range(7);
            mask_sub = 8'd1 << $urandom_range(7);
         end
         default: begin
            mask_main = 8'($urandom);
            mask_sub = 8'($urandom);
         end
      endcase
      heat = $urandom_range(1) ? 8'($urandom_range(20, 110)) : 8'($urandom_range(255));
      shower_temp = $urandom_range(1) ? 8'($urandom_range(20, 110))
                                      : 8'($urandom_range(255));
      send_request(bcfb_pkg::KIND_BUILD, mask_main, mask_sub, 1'($urandom_range(1)), heat,
                   shower_temp);
   endtask

   task automatic run_random_phase(input int count);
      int n;
      int extra;
      n = 0;
      while (n < count) begin
         if ($urandom_range(7) == 0) begin
            send_request(bcfb_pkg::KIND_RESET, 8'($urandom), 8'($urandom),
                         1'($urandom_range(1)), 8'($urandom), 8'($urandom));
            if ($urandom_range(3) == 0)
               send_request(bcfb_pkg::KIND_RESET, 8'($urandom), 8'($urandom),
                            1'($urandom_range(1)), 8'($urandom), 8'($urandom));
            extra = $urandom_range(2, 5);
            for (int k = 0; k < extra; k++) send_random_frame();
            n = n + extra + 1;
         end else begin
            send_random_frame();
            n++;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(bcfb_pkg::KIND_BUILD, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0);
      send_request(bcfb_pkg::KIND_BUILD, 8'h00, 8'h00, 1'b1, 8'd255, 8'd255);
      send_request(bcfb_pkg::KIND_BUILD, 8'h01, 8'h00, 1'b0, 8'd60, 8'd40);
      send_request(bcfb_pkg::KIND_BUILD, 8'h01, 8'h02, 1'b1, 8'd45, 8'd35);
      send_request(bcfb_pkg::KIND_BUILD, 8'h07, 8'h05, 1'b0, 8'd85, 8'd99);
      send_request(bcfb_pkg::KIND_BUILD, 8'h0F, 8'h00, 1'b1, 8'd86, 8'd100);
      send_request(bcfb_pkg::KIND_BUILD, 8'hFF, 8'hFF, 1'b1, 8'd44, 8'd34);
      send_request(bcfb_pkg::KIND_BUILD, 8'hAA, 8'h55, 1'b0, 8'd128, 8'd128);
      send_request(bcfb_pkg::KIND_RESET, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'hFF);
      send_request(bcfb_pkg::KIND_RESET, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00);
      send_request(bcfb_pkg::KIND_BUILD, 8'h03, 8'h00, 1'b0, 8'd50, 8'd50);
      send_request(bcfb_pkg::KIND_BUILD, 8'h00, 8'h00, 1'b1, 8'd50, 8'd50);
      send_request(bcfb_pkg::KIND_BUILD, 8'h30, 8'h00, 1'b1, 8'd50, 8'd50);
      send_request(bcfb_pkg::KIND_BUILD, 8'h80, 8'h00, 1'b0, 8'd50, 8'd50);
      drain_frames();

      set_limits(7'd0, 7'd127, 7'd0, 2'd0);
      send_request(bcfb_pkg::KIND_BUILD, 8'h10, 8'h01, 1'b0, 8'd255, 8'd0);
      send_request(bcfb_pkg::KIND_BUILD, 8'h00, 8'h00, 1'b0, 8'd0, 8'd9);
      send_request(bcfb_pkg::KIND_RESET, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0);
      send_request(bcfb_pkg::KIND_BUILD, 8'h01, 8'h00, 1'b1, 8'd99, 8'd100);
      send_request(bcfb_pkg::KIND_BUILD, 8'h01, 8'h00, 1'b1, 8'd100, 8'd10);
      drain_frames();

      set_limits(7'd127, 7'd0, 7'd127, 2'd3);
      send_request(bcfb_pkg::KIND_RESET, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0);
      for (int k = 0; k < 5; k++)
         send_request(bcfb_pkg::KIND_BUILD, 8'h0F, 8'hF0, k[0], 8'd255, 8'd0);
      drain_frames();

      set_limits(7'($urandom_range(0, 60)), 7'($urandom_range(40, 127)),
                 7'($urandom_range(0, 99)), 2'($urandom_range(3)));
      run_random_phase(25);
      drain_frames();

      tx_idle_pct = 48;
      rx_idle_pct = 18;
      set_limits(7'($urandom_range(0, 60)), 7'($urandom_range(40, 127)),
                 7'($urandom_range(0, 127)), 2'($urandom_range(3)));
      run_random_phase(25);
      drain_frames();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_limits(7'($urandom_range(0, 60)), 7'($urandom_range(40, 99)),
                 7'($urandom_range(0, 99)), 2'($urandom_range(3)));
      long_stalls_asked++;
      run_random_phase(25);
      drain_frames();

      @(negedge clock);
      if (mismatches == 0 && bytes_due == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire
